// ----- sv/bse_pkg.sv -----
// ---------------------------------------------------------------------------
// Battery SOC estimator package
// Shared widths, register indexes and the open-circuit voltage table.
// ---------------------------------------------------------------------------
package bse_pkg;

  localparam int unsigned ChargeW = 28;
  localparam int unsigned OcvPoints = 101;

  localparam logic [1:0] RegRatedCap = 2'd0;
  localparam logic [1:0] RegOverVolt = 2'd1;
  localparam logic [1:0] RegUnderVolt = 2'd2;

  localparam logic [2:0] ModeStandby = 3'd0;
  localparam logic [2:0] ModeCharge = 3'd1;
  localparam logic [2:0] ModeDischarge = 3'd2;
  localparam logic [2:0] ModeSleep = 3'd3;

  typedef struct packed {
    logic        func;
    logic [2:0]  sys_mode;
    logic [12:0] min_cell_mv;
    logic [18:0] current_ma;
    logic [11:0] min_temp_decideg;
    logic        temp_valid;
  } in_item_t;

  typedef struct packed {
    logic [9:0]  soc_permille;
    logic [16:0] remaining_mah;
    logic [16:0] real_capacity_mah;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } cfg_item_t;

  // Divider job: quotient of num / den, both unsigned, numerator up to 40 bits.
  typedef struct packed {
    logic        start;
    logic [39:0] num;
    logic [27:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [39:0] quo;
  } div_rsp_t;

  function automatic logic [12:0] ocv_mv(input logic [6:0] idx);
    logic [12:0] r;
    case (idx)
      7'd0: r = 13'd3282; 7'd1: r = 13'd3309; 7'd2: r = 13'd3334; 7'd3: r = 13'd3357;
      7'd4: r = 13'd3378; 7'd5: r = 13'd3398; 7'd6: r = 13'd3417; 7'd7: r = 13'd3434;
      7'd8: r = 13'd3449; 7'd9: r = 13'd3464; 7'd10: r = 13'd3477; 7'd11: r = 13'd3489;
      7'd12: r = 13'd3500; 7'd13: r = 13'd3510; 7'd14: r = 13'd3520; 7'd15: r = 13'd3528;
      7'd16: r = 13'd3536; 7'd17: r = 13'd3543; 7'd18: r = 13'd3549; 7'd19: r = 13'd3555;
      7'd20: r = 13'd3561; 7'd21: r = 13'd3566; 7'd22: r = 13'd3571; 7'd23: r = 13'd3575;
      7'd24: r = 13'd3579; 7'd25: r = 13'd3583; 7'd26: r = 13'd3586; 7'd27: r = 13'd3590;
      7'd28: r = 13'd3593; 7'd29: r = 13'd3596; 7'd30: r = 13'd3599; 7'd31: r = 13'd3602;
      7'd32: r = 13'd3605; 7'd33: r = 13'd3608; 7'd34: r = 13'd3611; 7'd35: r = 13'd3615;
      7'd36: r = 13'd3618; 7'd37: r = 13'd3621; 7'd38: r = 13'd3624; 7'd39: r = 13'd3628;
      7'd40: r = 13'd3632; 7'd41: r = 13'd3636; 7'd42: r = 13'd3640; 7'd43: r = 13'd3644;
      7'd44: r = 13'd3648; 7'd45: r = 13'd3653; 7'd46: r = 13'd3658; 7'd47: r = 13'd3663;
      7'd48: r = 13'd3668; 7'd49: r = 13'd3674; 7'd50: r = 13'd3679; 7'd51: r = 13'd3685;
      7'd52: r = 13'd3691; 7'd53: r = 13'd3698; 7'd54: r = 13'd3704; 7'd55: r = 13'd3711;
      7'd56: r = 13'd3718; 7'd57: r = 13'd3725; 7'd58: r = 13'd3733; 7'd59: r = 13'd3741;
      7'd60: r = 13'd3748; 7'd61: r = 13'd3756; 7'd62: r = 13'd3765; 7'd63: r = 13'd3773;
      7'd64: r = 13'd3782; 7'd65: r = 13'd3791; 7'd66: r = 13'd3800; 7'd67: r = 13'd3809;
      7'd68: r = 13'd3818; 7'd69: r = 13'd3827; 7'd70: r = 13'd3837; 7'd71: r = 13'd3847;
      7'd72: r = 13'd3857; 7'd73: r = 13'd3867; 7'd74: r = 13'd3877; 7'd75: r = 13'd3887;
      7'd76: r = 13'd3897; 7'd77: r = 13'd3908; 7'd78: r = 13'd3919; 7'd79: r = 13'd3929;
      7'd80: r = 13'd3940; 7'd81: r = 13'd3951; 7'd82: r = 13'd3962; 7'd83: r = 13'd3973;
      7'd84: r = 13'd3985; 7'd85: r = 13'd3996; 7'd86: r = 13'd4008; 7'd87: r = 13'd4019;
      7'd88: r = 13'd4031; 7'd89: r = 13'd4043; 7'd90: r = 13'd4055; 7'd91: r = 13'd4067;
      7'd92: r = 13'd4080; 7'd93: r = 13'd4092; 7'd94: r = 13'd4105; 7'd95: r = 13'd4118;
      7'd96: r = 13'd4131; 7'd97: r = 13'd4145; 7'd98: r = 13'd4158; 7'd99: r = 13'd4172;
      7'd100: r = 13'd4185;
      default: r = 13'd4185;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/bse_if.sv -----
// ---------------------------------------------------------------------------
// Valid/ready channels
// Stream interfaces for input items, result items and configuration writes.
// ---------------------------------------------------------------------------
interface bse_in_if;
  logic                valid;
  logic                ready;
  bse_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bse_out_if;
  logic                valid;
  logic                ready;
  bse_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bse_cfg_if;
  logic                valid;
  logic                ready;
  bse_pkg::cfg_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/bse_div.sv -----
// ---------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle over a 40-bit numerator.
// ---------------------------------------------------------------------------
module bse_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bse_pkg::div_req_t req_i,
  output bse_pkg::div_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [39:0] quo_q, quo_d;
  logic [28:0] rem_q, rem_d;
  logic [27:0] den_q, den_d;
  logic        done_q, done_d;
  logic [29:0] trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[39]} - {2'b00, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (!trial[29]) begin
        rem_d = trial[28:0];
      end else begin
        rem_d = {rem_q[27:0], quo_q[39]};
      end
      quo_d = {quo_q[38:0], ~trial[29]};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd39) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ----- sv/bse_mul.sv -----
// ---------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-and-add product of a 28-bit and a 12-bit operand, one bit per cycle.
// ---------------------------------------------------------------------------
module bse_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [27:0] a_i,
  input  logic [11:0] b_i,
  output logic        done_o,
  output logic [39:0] prod_o
);

  logic        busy_q;
  logic [3:0]  cnt_q;
  logic [39:0] acc_q;
  logic [39:0] a_q;
  logic [11:0] b_q;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd11) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= {12'd0, a_i};
      b_q   <= b_i;
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_q <= acc_q + a_q;
      end
      a_q <= {a_q[38:0], 1'b0};
      b_q <= {1'b0, b_q[11:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- sv/battery_soc_estimator_top.sv -----
// ---------------------------------------------------------------------------
// Battery SOC estimator
// Coulomb counting with open-circuit voltage calibration.
// ---------------------------------------------------------------------------
// Usage: input transactions arrive on in_if and one result per transaction
// leaves on out_if. Register writes arrive on cfg_if, are always accepted and
// are only defined while no transaction is in flight. One transaction is
// processed at a time: a sequencer walks the OCV table one point per cycle
// and shares a bit-serial multiplier and a restoring divider. A tick with a
// temperature reading can derate the capacity, and a tick in sleep mode
// recalibrates from the OCV table. The input is ready again as soon as a
// result is loaded into the output register. While the receiver stalls, the
// result waits in the output register, the next transaction is still accepted
// and processed, and its result is held back until the output register is
// free; only then is the input ready again. Reset clears the charge, the
// capacity and the derating temperature to zero and the registers to their
// defaults.
// ---------------------------------------------------------------------------
module battery_soc_estimator_top (
  input logic        clk_i,
  input logic        rst_ni,
  bse_in_if.sink     in_if,
  bse_out_if.source  out_if,
  bse_cfg_if.sink    cfg_if
);

  localparam logic [4:0] StIdle    = 5'd0;
  localparam logic [4:0] StSearch  = 5'd1;
  localparam logic [4:0] StTabDiv  = 5'd2;
  localparam logic [4:0] StTabWait = 5'd3;
  localparam logic [4:0] StSocMul  = 5'd4;
  localparam logic [4:0] StSocMulW = 5'd5;
  localparam logic [4:0] StSocDivW = 5'd6;
  localparam logic [4:0] StDerate  = 5'd7;
  localparam logic [4:0] StDrMulW  = 5'd8;
  localparam logic [4:0] StDrDivW  = 5'd9;
  localparam logic [4:0] StRsMulW  = 5'd10;
  localparam logic [4:0] StRsDivW  = 5'd11;
  localparam logic [4:0] StMode    = 5'd12;
  localparam logic [4:0] StOutMul  = 5'd13;
  localparam logic [4:0] StOutMulW = 5'd14;
  localparam logic [4:0] StOutDivW = 5'd15;
  localparam logic [4:0] StRemDivW = 5'd16;
  localparam logic [4:0] StCapDivW = 5'd17;
  localparam logic [4:0] StEmit    = 5'd18;
  localparam logic [4:0] StDrStart = 5'd19;
  localparam logic [4:0] StAfterDr = 5'd20;

  logic [4:0]  state_q;
  logic [15:0] rated_q;
  logic [12:0] ovp_q, uvp_q;
  logic [27:0] rem_q, real_q;
  logic [11:0] last_t_q;
  bse_pkg::in_item_t item_q;
  logic [6:0]  idx_q;
  logic [9:0]  soc_q;
  logic [27:0] old_real_q;
  logic        out_valid_q;
  bse_pkg::out_item_t out_q;
  bse_pkg::out_item_t res_q;
  logic signed [15:0] kprod_q;

  bse_pkg::div_req_t div_req;
  bse_pkg::div_rsp_t div_rsp;
  logic        mul_start, mul_done;
  logic [27:0] mul_a;
  logic [11:0] mul_b;
  logic [39:0] mul_p;

  bse_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req), .rsp_o(div_rsp));
  bse_mul u_mul (.clk_i(clk_i), .rst_ni(rst_ni), .start_i(mul_start), .a_i(mul_a),
                 .b_i(mul_b), .done_o(mul_done), .prod_o(mul_p));

  logic [12:0] v, tab_lo, tab_hi;
  logic        in_fire, out_fire;
  logic signed [11:0] t;
  logic signed [12:0] dt;
  logic [2:0]  k;
  logic signed [12:0] tm;
  logic signed [15:0] kprod;
  logic [15:0] kmag;
  logic [27:0] kmul;
  logic [11:0] kqm;
  logic signed [11:0] kq;
  logic signed [12:0] rate_raw;
  logic [10:0] rate;
  logic [18:0] mag;
  logic [28:0] sum_c;
  logic [28:0] dif_c;
  logic [27:0] rated_x;

  assign v       = item_q.min_cell_mv;
  assign tab_lo  = bse_pkg::ocv_mv(idx_q);
  assign tab_hi  = bse_pkg::ocv_mv(idx_q + 7'd1);
  assign in_fire = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign t       = item_q.min_temp_decideg;
  assign dt      = $signed({t[11], t}) - $signed({last_t_q[11], last_t_q});
  assign tm      = $signed({t[11], t}) - 13'sd250;
  assign mag     = item_q.current_ma[18] ? 19'(-item_q.current_ma) : item_q.current_ma;
  assign sum_c   = {1'b0, rem_q} + {10'd0, mag};
  assign dif_c   = {1'b0, rem_q} - {10'd0, mag};
  assign rated_x = {12'd0, rated_q};

  always_comb begin
    if (t >= 12'sd250) k = 3'd1;
    else if (t >= 12'sd100) k = 3'd2;
    else if (t >= 12'sd0) k = 3'd3;
    else if (t >= -12'sd200) k = 3'd4;
    else if (t >= -12'sd300) k = 3'd5;
    else k = 3'd6;
    kprod = $signed({{3{tm[12]}}, tm}) * $signed({13'd0, k});
  end

  // The quotient by ten of the registered product, truncated toward zero,
  // comes from a multiplication by 6554 and a shift by 16 of its magnitude.
  always_comb begin
    kmag = kprod_q[15] ? 16'(-kprod_q) : 16'(kprod_q);
    kmul = {12'd0, kmag} * 28'd6554;
    kqm  = kmul[27:16];
    kq   = kprod_q[15] ? $signed(-kqm) : $signed(kqm);
    rate_raw = 13'sd1000 + 13'(kq);
    if (rate_raw > 13'sd1050) rate = 11'd1050;
    else if (rate_raw < 13'sd750) rate = 11'd750;
    else rate = 11'(rate_raw);
  end

  assign in_if.ready  = (state_q == StIdle);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_q;

  always_comb begin
    div_req   = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_q)
      StTabDiv: begin
        div_req.start = 1'b1;
        div_req.num   = 40'({v - tab_lo, 3'd0} + {2'd0, v - tab_lo, 1'b0});
        div_req.den   = 28'(tab_hi - tab_lo);
      end
      StSocMul: begin
        mul_start = 1'b1;
        mul_a = real_q;
        mul_b = {2'd0, soc_q};
      end
      StSocMulW: begin
        div_req.start = mul_done;
        div_req.num   = mul_p + 40'd999;
        div_req.den   = 28'd1000;
      end
      StDerate: begin
        mul_start = 1'b1;
        mul_a = 28'(rated_x * 28'd3600);
        mul_b = {1'b0, rate};
      end
      StDrMulW: begin
        div_req.start = mul_done;
        div_req.num   = mul_p;
        div_req.den   = 28'd1000;
      end
      StDrStart: begin
        mul_start = 1'b1;
        mul_a = rem_q;
        mul_b = '0;
      end
      StOutMul: begin
        mul_start = 1'b1;
        mul_a = rem_q;
        mul_b = 12'd1000;
      end
      StOutMulW: begin
        div_req.start = mul_done;
        div_req.num   = mul_p;
        div_req.den   = real_q;
      end
      StOutDivW: begin
        div_req.start = div_rsp.done;
        div_req.num   = {12'd0, rem_q};
        div_req.den   = 28'd3600;
      end
      StRemDivW: begin
        div_req.start = div_rsp.done;
        div_req.num   = {12'd0, real_q};
        div_req.den   = 28'd3600;
      end
      default: begin
      end
    endcase
  end

  // Rescaling remaining*new/old: a shift-and-add product over the 28 bits of
  // the remaining charge, then a restoring division by the old capacity with
  // one quotient bit per cycle over 56 bits.
  logic [55:0] rs_acc_q;
  logic [27:0] rs_a_q;
  logic [4:0]  rs_cnt_q;
  logic [56:0] rs_rem_q;
  logic [55:0] rs_quo_q;
  logic [6:0]  rs_dcnt_q;
  logic [57:0] rs_trial;

  assign rs_trial = {rs_rem_q[55:0], rs_quo_q[55]} - {30'd0, old_real_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rated_q     <= 16'd10000;
      ovp_q       <= 13'd3650;
      uvp_q       <= 13'd2500;
      rem_q       <= '0;
      real_q      <= '0;
      last_t_q    <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      soc_q       <= '0;
      rs_cnt_q    <= '0;
      rs_dcnt_q   <= '0;
      old_real_q  <= '0;
      kprod_q     <= '0;
      rs_acc_q    <= '0;
      rs_a_q      <= '0;
      rs_rem_q    <= '0;
      rs_quo_q    <= '0;
      out_q       <= '0;
      res_q       <= '0;
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.data.index)
          bse_pkg::RegRatedCap:  rated_q <= cfg_if.data.data;
          bse_pkg::RegOverVolt:  ovp_q <= cfg_if.data.data[12:0];
          bse_pkg::RegUnderVolt: uvp_q <= cfg_if.data.data[12:0];
          default: begin
          end
        endcase
      end
      if (out_fire) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            idx_q <= '0;
            if (!in_if.data.func) begin
              real_q  <= 28'(rated_x * 28'd3600);
              state_q <= StSearch;
            end else if (in_if.data.temp_valid) begin
              state_q <= StDrStart;
            end else begin
              state_q <= StAfterDr;
            end
          end
        end
        StDrStart: begin
          if (dt < 13'sd10 && dt > -13'sd10) begin
            state_q <= StAfterDr;
          end else begin
            last_t_q   <= t;
            old_real_q <= real_q;
            kprod_q    <= kprod;
            state_q    <= StDerate;
          end
        end
        StDerate: state_q <= StDrMulW;
        StDrMulW: if (mul_done) state_q <= StDrDivW;
        StDrDivW: begin
          if (div_rsp.done) begin
            real_q   <= div_rsp.quo[27:0];
            rs_acc_q <= '0;
            rs_a_q   <= div_rsp.quo[27:0];
            rs_cnt_q <= '0;
            state_q  <= StRsMulW;
          end
        end
        StRsMulW: begin
          if (rem_q[rs_cnt_q]) rs_acc_q <= rs_acc_q + ({28'd0, rs_a_q} << rs_cnt_q);
          rs_cnt_q <= rs_cnt_q + 5'd1;
          if (rs_cnt_q == 5'd27) begin
            rs_dcnt_q <= '0;
            rs_rem_q  <= '0;
            state_q   <= StRsDivW;
          end
        end
        StRsDivW: begin
          if (rs_dcnt_q == 7'd0 && rs_rem_q == 57'd0 && rs_cnt_q == 5'd28) begin
            rs_quo_q <= rs_acc_q;
            rs_cnt_q <= '0;
          end else if (old_real_q == 28'd0) begin
            rem_q   <= '0;
            state_q <= StAfterDr;
          end else begin
            if (!rs_trial[57]) rs_rem_q <= rs_trial[56:0];
            else rs_rem_q <= {rs_rem_q[55:0], rs_quo_q[55]};
            rs_quo_q  <= {rs_quo_q[54:0], ~rs_trial[57]};
            rs_dcnt_q <= rs_dcnt_q + 7'd1;
            if (rs_dcnt_q == 7'd55) begin
              if ({rs_quo_q[54:0], ~rs_trial[57]} > {28'd0, real_q}) rem_q <= real_q;
              else rem_q <= {rs_quo_q[26:0], ~rs_trial[57]};
              state_q <= StAfterDr;
            end
          end
        end
        StAfterDr: begin
          if (item_q.sys_mode == bse_pkg::ModeSleep) state_q <= StSearch;
          else state_q <= StMode;
        end
        StSearch: begin
          if (v <= 13'd3282) begin
            soc_q <= '0;
            state_q <= StSocMul;
          end else if (v >= 13'd4185) begin
            soc_q <= 10'd1000;
            state_q <= StSocMul;
          end else if (idx_q < 7'd99 && tab_hi <= v) begin
            idx_q <= idx_q + 7'd1;
          end else begin
            state_q <= StTabDiv;
          end
        end
        StTabDiv: state_q <= StTabWait;
        StTabWait: begin
          if (div_rsp.done) begin
            soc_q   <= 10'({3'd0, idx_q} * 10'd10 + 10'(div_rsp.quo[3:0]));
            state_q <= StSocMul;
          end
        end
        StSocMul: state_q <= StSocMulW;
        StSocMulW: if (mul_done) state_q <= StSocDivW;
        StSocDivW: begin
          if (div_rsp.done) begin
            rem_q   <= div_rsp.quo[27:0];
            state_q <= item_q.func ? StMode : StOutMul;
          end
        end
        StMode: begin
          state_q <= StOutMul;
          if (item_q.func) begin
            case (item_q.sys_mode)
              bse_pkg::ModeStandby: begin
                if (v >= ovp_q) rem_q <= real_q;
                else if (v <= uvp_q) rem_q <= '0;
              end
              bse_pkg::ModeCharge: begin
                rem_q <= (sum_c > {1'b0, real_q}) ? real_q : sum_c[27:0];
              end
              bse_pkg::ModeDischarge: begin
                rem_q <= dif_c[28] ? 28'd0 : dif_c[27:0];
              end
              default: begin
              end
            endcase
          end
        end
        StOutMul: state_q <= StOutMulW;
        StOutMulW: if (mul_done) state_q <= StOutDivW;
        StOutDivW: begin
          if (div_rsp.done) begin
            if (real_q == 28'd0) res_q.soc_permille <= '0;
            else if (div_rsp.quo > 40'd1000) res_q.soc_permille <= 10'd1000;
            else res_q.soc_permille <= div_rsp.quo[9:0];
            state_q <= StRemDivW;
          end
        end
        StRemDivW: begin
          if (div_rsp.done) begin
            res_q.remaining_mah <= div_rsp.quo[16:0];
            state_q <= StCapDivW;
          end
        end
        StCapDivW: begin
          if (div_rsp.done) begin
            res_q.real_capacity_mah <= div_rsp.quo[16:0];
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (!out_valid_q || out_if.ready) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) item_q <= in_if.data;
  end

endmodule
